### hw/rtl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrs_pkg: shared types and constants of the periodic task release scheduler
// Table size, action, status and task mode codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_DISPATCH = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_READ     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NONE_READY = 3'd2,
    ST_BAD_SLOT   = 3'd3,
    ST_STOPPED    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_EXECUTING = 2'd1,
    MODE_BLOCKING  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic latch;      // capture the input transfer
    logic scan_step;  // visit one table entry
    logic apply;      // final update and result load
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;  // incoming action walks the table
    logic scan_last;  // current entry is the last one
  } dpath_stat_t;

endpackage

### hw/rtl/ptrs_ctrl.sv
// ----------------------------------------------------------------------------
// ptrs_ctrl: scheduler sequencer
// Accepts one item at a time, walks the table for an enabled tick and for a
// dispatch, and loads the output register once it is free.
// ----------------------------------------------------------------------------
module ptrs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  ptrs_pkg::dpath_stat_t  stat_i,
  output ptrs_pkg::ctrl_cmd_t    cmd_o
);
  import ptrs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = stat_i.need_scan ? S_SCAN : S_APPLY;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.latch     = accept;
      S_SCAN:  cmd_o.scan_step = 1'b1;
      S_APPLY: cmd_o.apply     = out_free;
      default: cmd_o           = '0;
    endcase
  end

  // hold the result while the receiver stalls
  assign out_valid_d = cmd_o.apply || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_apply_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending transfer");

  a_apply_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> out_valid_q)
    else $error("loaded result not presented");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_step && stat_i.scan_last) |=> (state_q == S_APPLY))
    else $error("scan did not end in apply");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> in_stall_o)
    else $error("second item taken while busy");

endmodule

### hw/rtl/ptrs_dpath.sv
// ----------------------------------------------------------------------------
// ptrs_dpath: scheduler datapath
// Task table with one read port, tick counter, fill count, scan index and
// best-candidate registers, and the output payload register.
// ----------------------------------------------------------------------------
module ptrs_dpath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic [2:0]             action_i,
  input  logic [7:0]             task_id_i,
  input  logic [7:0]             period_i,
  input  logic [7:0]             priority_req_i,
  input  logic [2:0]             slot_i,
  input  ptrs_pkg::ctrl_cmd_t    cmd_i,
  output ptrs_pkg::dpath_stat_t  stat_o,
  output logic [2:0]             status_o,
  output logic [2:0]             result_slot_o,
  output logic [7:0]             result_id_o,
  output logic [15:0]            missed_count_o,
  output logic [1:0]             task_status_o
);
  import ptrs_pkg::*;

  // table
  logic        ent_valid_q  [MAX_TASKS];
  logic [7:0]  ent_ident_q  [MAX_TASKS];
  logic [7:0]  ent_period_q [MAX_TASKS];
  logic [7:0]  ent_rank_q   [MAX_TASKS];
  logic [7:0]  ent_expiry_q [MAX_TASKS];
  mode_e       ent_mode_q   [MAX_TASKS];
  logic [15:0] ent_missed_q [MAX_TASKS];

  logic             tick_en_q;
  logic [7:0]       tick_q;
  logic [CNT_W-1:0] total_q;

  // captured item
  action_e     act_q;
  logic [7:0]  id_q;
  logic [7:0]  period_q;
  logic [7:0]  prio_q;
  logic [2:0]  slot_q;

  // scan
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] best_q;
  logic [7:0]       best_rank_q;
  logic             found_q;

  // result
  status_e     res_status_q, res_status_d;
  logic [2:0]  res_slot_q, res_slot_d;
  logic [7:0]  res_id_q, res_id_d;
  logic [15:0] res_missed_q, res_missed_d;
  mode_e       res_mode_q, res_mode_d;

  logic [IDX_W-1:0] fill_idx;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             full;
  logic             slot_ok;
  logic             hit;
  logic             better;
  logic             rd_valid;
  logic [7:0]       rd_ident;
  logic [7:0]       rd_period;
  logic [7:0]       rd_rank;
  logic [7:0]       rd_expiry;
  mode_e            rd_mode;
  logic [15:0]      rd_missed;

  assign full     = (total_q == CNT_W'(MAX_TASKS));
  assign fill_idx = IDX_W'(total_q);
  assign slot_idx = IDX_W'(slot_q);
  assign rd_idx   = cmd_i.scan_step ? idx_q :
                    (act_q == ACT_DISPATCH) ? best_q : slot_idx;

  assign rd_valid  = ent_valid_q[rd_idx];
  assign rd_ident  = ent_ident_q[rd_idx];
  assign rd_period = ent_period_q[rd_idx];
  assign rd_rank   = ent_rank_q[rd_idx];
  assign rd_expiry = ent_expiry_q[rd_idx];
  assign rd_mode   = ent_mode_q[rd_idx];
  assign rd_missed = ent_missed_q[rd_idx];

  assign slot_ok = (32'(slot_q) < MAX_TASKS) && rd_valid;
  assign hit     = rd_valid && (rd_expiry == tick_q);
  assign better  = rd_valid && (rd_mode == MODE_READY) &&
                   (!found_q || (rd_rank < best_rank_q));

  assign stat_o.need_scan = ((action_i == ACT_TICK) && tick_en_q) ||
                            (action_i == ACT_DISPATCH);
  assign stat_o.scan_last = (idx_q == IDX_W'(MAX_TASKS - 1));

  always_comb begin
    res_status_d = ST_OK;
    res_slot_d   = '0;
    res_id_d     = '0;
    res_missed_d = '0;
    res_mode_d   = MODE_READY;
    unique case (act_q) inside
      ACT_ADD: begin
        if (full) begin
          res_status_d = ST_FULL;
        end else begin
          res_slot_d = 3'(fill_idx);
          res_id_d   = id_q;
        end
      end
      ACT_TICK: begin
        res_status_d = tick_en_q ? ST_OK : ST_STOPPED;
      end
      ACT_DISPATCH: begin
        if (found_q) begin
          res_slot_d   = 3'(best_q);
          res_id_d     = rd_ident;
          res_missed_d = rd_missed;
          res_mode_d   = MODE_EXECUTING;
        end else begin
          res_status_d = ST_NONE_READY;
        end
      end
      ACT_COMPLETE, ACT_READ: begin
        if (slot_ok) begin
          res_slot_d   = slot_q;
          res_id_d     = rd_ident;
          res_missed_d = rd_missed;
          res_mode_d   = (act_q == ACT_COMPLETE) ? MODE_BLOCKING : rd_mode;
        end else begin
          res_status_d = ST_BAD_SLOT;
        end
      end
      default: begin
        res_status_d = ST_BAD_SLOT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_en_q <= 1'b0;
      tick_q    <= '0;
      total_q   <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        ent_valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        tick_en_q <= cfg_wdata_i;
      end
      if (cmd_i.latch && (action_i == ACT_TICK) && tick_en_q) begin
        tick_q <= tick_q + 8'd1;
      end
      if (cmd_i.apply && (act_q == ACT_ADD) && !full) begin
        ent_valid_q[fill_idx] <= 1'b1;
        total_q               <= total_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q    <= action_e'(action_i);
      id_q     <= task_id_i;
      period_q <= period_i;
      prio_q   <= priority_req_i;
      slot_q   <= slot_i;
      idx_q    <= '0;
      found_q  <= 1'b0;
    end

    if (cmd_i.scan_step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (act_q == ACT_TICK) begin
        if (hit) begin
          // release a blocked task, otherwise count a missed deadline
          if (rd_mode == MODE_BLOCKING) begin
            ent_expiry_q[idx_q] <= rd_expiry + rd_period;
            ent_mode_q[idx_q]   <= MODE_READY;
          end else if (rd_missed != 16'hFFFF) begin
            ent_missed_q[idx_q] <= rd_missed + 16'd1;
          end
        end
      end else if (better) begin
        best_q      <= idx_q;
        best_rank_q <= rd_rank;
        found_q     <= 1'b1;
      end
    end

    if (cmd_i.apply) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_id_q     <= res_id_d;
      res_missed_q <= res_missed_d;
      res_mode_q   <= res_mode_d;
      if ((act_q == ACT_ADD) && !full) begin
        ent_ident_q[fill_idx]  <= id_q;
        ent_period_q[fill_idx] <= period_q;
        ent_rank_q[fill_idx]   <= prio_q;
        ent_expiry_q[fill_idx] <= period_q;
        ent_mode_q[fill_idx]   <= MODE_READY;
        ent_missed_q[fill_idx] <= '0;
      end
      if ((act_q == ACT_DISPATCH) && found_q) begin
        ent_mode_q[best_q] <= MODE_EXECUTING;
      end
      if ((act_q == ACT_COMPLETE) && slot_ok) begin
        ent_mode_q[slot_idx] <= MODE_BLOCKING;
      end
    end
  end

  assign status_o       = res_status_q;
  assign result_slot_o  = res_slot_q;
  assign result_id_o    = res_id_q;
  assign missed_count_o = res_missed_q;
  assign task_status_o  = res_mode_q;

endmodule

### hw/rtl/periodic_task_release_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_top: fixed-priority periodic task scheduler
// Table of periodic tasks with add, tick, dispatch, complete and read actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one action with its
//   operands; output channel (out_valid_o / out_stall_i) returns exactly one
//   result per action. A transfer happens at a clock edge with valid high and
//   stall low.
//   Add, complete, read, a stopped tick and an unknown action go from capture
//   to the final step that loads the result; an enabled tick or a dispatch
//   walks the table one entry per cycle through the single read port. One item
//   is in work at a time, so the input accepts again in the cycle after the
//   result is loaded. The result sits in an output register; a stalled
//   receiver holds it there and the final step of the next item waits until
//   it has been taken. Reset empties the table, clears the tick counter and
//   stops ticks. cfg_we_i / cfg_wdata_i write tick_enable; the user must do
//   so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  period_i,
  input  logic [7:0]  priority_req_i,
  input  logic [2:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  result_slot_o,
  output logic [7:0]  result_id_o,
  output logic [15:0] missed_count_o,
  output logic [1:0]  task_status_o
);
  import ptrs_pkg::*;

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  ptrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptrs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (action_i),
    .task_id_i      (task_id_i),
    .period_i       (period_i),
    .priority_req_i (priority_req_i),
    .slot_i         (slot_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .result_slot_o  (result_slot_o),
    .result_id_o    (result_id_o),
    .missed_count_o (missed_count_o),
    .task_status_o  (task_status_o)
  );

endmodule

### tb/sv/periodic_task_release_scheduler_checker.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_checker: result predictor and comparator
// Watches the config port and both channels of the scheduler, keeps its own
// copy of the task table, predicts one reply per accepted action and compares
// every accepted reply with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  action_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  period_i,
  input  logic [7:0]  priority_req_i,
  input  logic [2:0]  slot_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [2:0]  result_slot_i,
  input  logic [7:0]  result_id_i,
  input  logic [15:0] missed_count_i,
  input  logic [1:0]  task_status_i,
  output int          mismatches_o,
  output int          replies_due_o
);
  import ptrs_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slot;
    logic [7:0]  ident;
    logic [15:0] missed;
    mode_e       mode;
  } sched_reply_t;

  logic        ticks_on;
  logic [7:0]  tick_now;
  logic        slot_used   [MAX_TASKS];
  logic [7:0]  slot_ident  [MAX_TASKS];
  logic [7:0]  slot_period [MAX_TASKS];
  logic [7:0]  slot_rank   [MAX_TASKS];
  logic [7:0]  slot_due    [MAX_TASKS];
  mode_e       slot_mode   [MAX_TASKS];
  logic [15:0] slot_missed [MAX_TASKS];

  sched_reply_t replies_due_q[$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("sched_check: %s mismatch, got %0d, want %0d, at %0t",
             what, got, want, $time);
    mismatches_o++;
  endtask

  function automatic sched_reply_t entry_reply(int s);
    sched_reply_t r;
    r.status = ST_OK;
    r.slot   = 3'(s);
    r.ident  = slot_ident[s];
    r.missed = slot_missed[s];
    r.mode   = slot_mode[s];
    return r;
  endfunction

  // Apply one action to the table copy and return the reply it causes.
  function automatic sched_reply_t predict_action(logic [2:0] act,
                                                  logic [7:0] ident,
                                                  logic [7:0] per,
                                                  logic [7:0] prio,
                                                  logic [2:0] slot);
    sched_reply_t r;
    int best;
    r = '0;
    r.status = ST_OK;
    best = -1;
    case (act) inside
      ACT_ADD: begin
        for (int i = 0; i < MAX_TASKS; i++)
          if (!slot_used[i] && best < 0) best = i;
        if (best < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_used[best]   = 1'b1;
          slot_ident[best]  = ident;
          slot_period[best] = per;
          slot_rank[best]   = prio;
          slot_due[best]    = per;
          slot_mode[best]   = MODE_READY;
          slot_missed[best] = '0;
          r = entry_reply(best);
        end
      end
      ACT_TICK: begin
        if (!ticks_on) begin
          r.status = ST_STOPPED;
        end else begin
          tick_now = tick_now + 8'd1;
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (slot_used[i] && slot_due[i] == tick_now) begin
              if (slot_mode[i] == MODE_BLOCKING) begin
                slot_due[i]  = slot_due[i] + slot_period[i];
                slot_mode[i] = MODE_READY;
              end else if (slot_missed[i] != 16'hFFFF) begin
                slot_missed[i] = slot_missed[i] + 16'd1;
              end
            end
          end
        end
      end
      ACT_DISPATCH: begin
        // strict compare keeps the lowest (oldest) slot among equal ranks
        for (int i = 0; i < MAX_TASKS; i++)
          if (slot_used[i] && slot_mode[i] == MODE_READY &&
              (best < 0 || slot_rank[i] < slot_rank[best]))
            best = i;
        if (best < 0) begin
          r.status = ST_NONE_READY;
        end else begin
          slot_mode[best] = MODE_EXECUTING;
          r = entry_reply(best);
        end
      end
      ACT_COMPLETE, ACT_READ: begin
        if (int'(slot) >= MAX_TASKS || !slot_used[slot]) begin
          r.status = ST_BAD_SLOT;
        end else begin
          if (act == ACT_COMPLETE) slot_mode[slot] = MODE_BLOCKING;
          r = entry_reply(int'(slot));
        end
      end
      default: r.status = ST_BAD_SLOT;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_reply_t want;
    if (!rst_ni) begin
      ticks_on = 1'b0;
      tick_now = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_used[i]   = 1'b0;
        slot_ident[i]  = '0;
        slot_period[i] = '0;
        slot_rank[i]   = '0;
        slot_due[i]    = '0;
        slot_mode[i]   = MODE_READY;
        slot_missed[i] = '0;
      end
      replies_due_q.delete();
      mismatches_o  = 0;
      replies_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (replies_due_q.size() == 0) begin
          report_mismatch("unexpected reply, status", 16'(status_i), '0);
        end else begin
          want = replies_due_q.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", 16'(status_i), 16'(want.status));
          if (result_slot_i !== want.slot)
            report_mismatch("result_slot", 16'(result_slot_i), 16'(want.slot));
          if (result_id_i !== want.ident)
            report_mismatch("result_id", 16'(result_id_i), 16'(want.ident));
          if (missed_count_i !== want.missed)
            report_mismatch("missed_count", missed_count_i, want.missed);
          if (task_status_i !== want.mode)
            report_mismatch("task_status", 16'(task_status_i), 16'(want.mode));
        end
      end
      if (cfg_we_i) ticks_on = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        replies_due_q.push_back(predict_action(action_i, task_id_i, period_i,
                                               priority_req_i, slot_i));
      replies_due_o <= replies_due_q.size();
    end
  end

endmodule

### tb/sv/periodic_task_release_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_top_tb: scheduler testbench top
// Drives a directed sequence and then phases of random actions, with random
// idling on both channels, a long receiver hold-off and drains between
// phases; the checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_top_tb;
  import ptrs_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ITEMS = 1280;
  localparam int         PHASES       = 6;
  localparam int         IDLE_PCT     = 21;
  localparam int         HOLD_AFTER   = 300;
  localparam int         HOLD_CYCLES  = 400;
  localparam logic [PHASES-1:0] PHASE_TICKS = 6'b101101;
  localparam logic [2:0] ACT_BOGUS_LO = 3'd5;
  localparam logic [2:0] ACT_BOGUS_HI = 3'd7;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_wdata   = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [2:0]  action      = '0;
  logic [7:0]  task_id     = '0;
  logic [7:0]  period      = '0;
  logic [7:0]  priority_req = '0;
  logic [2:0]  slot        = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [2:0]  status;
  logic [2:0]  result_slot;
  logic [7:0]  result_id;
  logic [15:0] missed_count;
  logic [1:0]  task_status;

  logic        quiet       = 1'b0;
  int          added       = 0;
  int          cycles      = 0;
  int          taken       = 0;
  int          hold_left   = 0;
  logic        hold_done   = 1'b0;
  int          mismatches;
  int          replies_due;

  periodic_task_release_scheduler_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .task_id_i      (task_id),
    .period_i       (period),
    .priority_req_i (priority_req),
    .slot_i         (slot),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .result_slot_o  (result_slot),
    .result_id_o    (result_id),
    .missed_count_o (missed_count),
    .task_status_o  (task_status)
  );

  periodic_task_release_scheduler_checker sched_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .task_id_i      (task_id),
    .period_i       (period),
    .priority_req_i (priority_req),
    .slot_i         (slot),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .result_slot_i  (result_slot),
    .result_id_i    (result_id),
    .missed_count_i (missed_count),
    .task_status_i  (task_status),
    .mismatches_o   (mismatches),
    .replies_due_o  (replies_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall, plus one long hold-off after HOLD_AFTER transfers.
  always @(posedge clk) begin
    if (out_valid && !out_stall) taken <= taken + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && taken >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Leaves valid high after the transfer; the next call lowers or reloads it.
  task automatic send_item(input logic [2:0] act, input logic [7:0] ident,
                           input logic [7:0] per, input logic [7:0] prio,
                           input logic [2:0] sl);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    task_id      <= ident;
    period       <= per;
    priority_req <= prio;
    slot         <= sl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_ADD && added < MAX_TASKS) added++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  task automatic set_tick_enable(input logic en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed traffic on live slots, some noise on any slot.
  task automatic random_item();
    int         pick;
    logic [2:0] act;
    logic [2:0] sl;
    logic [7:0] per;
    pick = $urandom_range(0, 99);
    sl   = 3'($urandom_range(0, 7));
    per  = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 10)) : 8'($urandom);
    if (pick < 35) begin
      act = ACT_TICK;
    end else if (pick < 50) begin
      act = ACT_DISPATCH;
    end else if (pick < 85) begin
      act = (pick < 75) ? ACT_COMPLETE : ACT_READ;
      if (added > 0) sl = 3'($urandom_range(0, added - 1));
    end else if (pick < 90) begin
      act = ACT_ADD;
    end else if (pick < 95) begin
      act = pick[0] ? ACT_COMPLETE : ACT_READ;
    end else begin
      act = 3'($urandom_range(ACT_BOGUS_LO, ACT_BOGUS_HI));
    end
    send_item(act, 8'($urandom), per, 8'($urandom), sl);
  endtask

  initial begin
    int ph;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_tick_enable(1'b0);

    // empty table, stopped ticks, unknown actions
    send_item(ACT_READ,     8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_COMPLETE, 8'd0, 8'd0, 8'd0, 3'd5);
    send_item(ACT_DISPATCH, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_TICK,     8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_BOGUS_LO, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(3'(ACT_BOGUS_LO + 3'd1), 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_BOGUS_HI, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    // field extremes, zero period, three tasks of equal rank
    send_item(ACT_ADD, 8'hFF, 8'd1,   8'hFF, 3'd0);
    send_item(ACT_ADD, 8'h00, 8'hFF,  8'h00, 3'd0);
    send_item(ACT_ADD, 8'h5A, 8'd0,   8'h40, 3'd0);
    send_item(ACT_ADD, 8'hA5, 8'd3,   8'h40, 3'd0);
    send_item(ACT_ADD, 8'h3C, 8'd2,   8'h40, 3'd0);
    send_item(ACT_DISPATCH, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_DISPATCH, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_DISPATCH, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_COMPLETE, 8'd0, 8'd0, 8'd0, 3'd1);
    send_item(ACT_COMPLETE, 8'd0, 8'd0, 8'd0, 3'd4);
    send_item(ACT_READ,     8'd0, 8'd0, 8'd0, 3'd2);
    wait_drained();
    set_tick_enable(1'b1);
    repeat (5) send_item(ACT_TICK, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_READ,     8'd0, 8'd0, 8'd0, 3'd0);
    send_item(ACT_DISPATCH, 8'd0, 8'd0, 8'd0, 3'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      set_tick_enable(PHASE_TICKS[ph]);
      quiet <= (ph == 3);
      repeat (RANDOM_ITEMS / PHASES) random_item();
    end

    wait_drained();
    repeat (MAX_TASKS + 4) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ptrs_pkg.sv
hw/rtl/ptrs_ctrl.sv
hw/rtl/ptrs_dpath.sv
hw/rtl/periodic_task_release_scheduler_top.sv
tb/sv/periodic_task_release_scheduler_checker.sv
tb/sv/periodic_task_release_scheduler_top_tb.sv
